// ===== sv/yqse_pkg.sv =====
// ----------------------------------------------------------------------------
// yqse_pkg
// Shared types, constants and helper functions of the YAML quoted string
// escaper: the UTF-8 validation table, byte classes and the command format
// that travels from the front end to the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package yqse_pkg;

  // Bytes one command can carry: opening quote, six escape bytes, closing quote.
  localparam int NCHAR    = 8;
  localparam int NCONTENT = 6;
  localparam int CNT_W    = 4;
  localparam int IDX_W    = 3;

  // Command queue between front end and output sequencer.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QLVL_W = 3;
  localparam logic [QLVL_W-1:0] LVL_FULL = 3'd4;

  // Validation automaton.
  localparam int NSTATE = 9;
  localparam int NCLASS = 12;
  localparam logic [3:0] ST_ACCEPT = 4'd0;
  localparam logic [3:0] ST_REJECT = 4'd1;
  localparam logic [3:0] ST_LAST   = 4'd8;

  localparam logic [3:0] NEXT_STATE [NSTATE*NCLASS] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1,
    4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1,
    4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1,
    4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
  };

  // Characters used in the output text.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_UP_N   = 8'h4E;
  localparam logic [7:0] CH_UP_L   = 8'h4C;
  localparam logic [7:0] CH_UP_P   = 8'h50;

  typedef struct packed {
    logic [NCHAR-1:0][7:0] chars;
    logic [CNT_W-1:0]      count;
    logic                  close;
    logic                  bad;
  } cmd_t;

  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] cls;
    if (b < 8'h80)       cls = 4'd0;
    else if (b < 8'h90)  cls = 4'd1;
    else if (b < 8'hA0)  cls = 4'd9;
    else if (b < 8'hC0)  cls = 4'd7;
    else if (b < 8'hC2)  cls = 4'd8;
    else if (b < 8'hE0)  cls = 4'd2;
    else if (b == 8'hE0) cls = 4'd10;
    else if (b == 8'hED) cls = 4'd4;
    else if (b < 8'hF0)  cls = 4'd3;
    else if (b == 8'hF0) cls = 4'd11;
    else if (b < 8'hF4)  cls = 4'd6;
    else if (b == 8'hF4) cls = 4'd5;
    else                 cls = 4'd8;
    return cls;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] ch;
    if (v < 4'd10) ch = 8'h30 + {4'h0, v};
    else           ch = 8'h37 + {4'h0, v};
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== sv/yqse_front.sv =====
// ----------------------------------------------------------------------------
// yqse_front
// Accepts one source byte per cycle unless q_full, steps the UTF-8 validation
// automaton and turns the byte into a command: all the output bytes it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module yqse_front
  import yqse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       data_valid,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_string,
  input  wire logic       q_full,
  output logic            data_stall,
  output logic            push,
  output cmd_t            cmd
);

  logic [3:0]  decoder_state;
  logic [20:0] code_accum;
  logic [7:0]  held_bytes [3];
  logic [1:0]  held_count;
  logic        string_open;
  logic        error_seen;

  logic              accept;
  logic [3:0]        eff_state;
  logic [3:0]        cls;
  logic [6:0]        tbl_idx;
  logic [3:0]        ns;
  logic              active;
  logic [20:0]       accum_next;
  logic [7:0]        content [NCONTENT];
  logic [2:0]        content_cnt;
  logic              error_next;
  logic [3:0]        state_after;
  logic              hold_byte;

  assign data_stall = q_full;
  assign accept     = data_valid && !q_full;

  always_comb begin
    eff_state = (decoder_state > ST_LAST) ? ST_REJECT : decoder_state;
    cls       = byte_class(data_byte);
    tbl_idx   = 7'({3'b000, eff_state} * 7'd12 + {3'b000, cls});
    ns        = NEXT_STATE[tbl_idx];
    active    = (eff_state != ST_REJECT);
    if (eff_state != ST_ACCEPT) begin
      accum_next = {code_accum[14:0], data_byte[5:0]};
    end else begin
      accum_next = {13'b0, data_byte & (8'hFF >> cls)};
    end
    error_next  = error_seen || (active && ns == ST_REJECT);
    state_after = active ? ns : eff_state;
    hold_byte   = active && ns != ST_ACCEPT && ns != ST_REJECT && held_count < 2'd3;
  end

  // Escape mapping of a completed code point.
  always_comb begin
    for (int k = 0; k < NCONTENT; k++) begin
      content[k] = 8'h00;
    end
    content_cnt = 3'd0;
    if (active && ns == ST_ACCEPT) begin
      if (accum_next <= 21'h7F) begin
        if (accum_next >= 21'h20 && accum_next <= 21'h7E) begin
          if (accum_next[7:0] == CH_QUOTE || accum_next[7:0] == CH_BSLASH) begin
            content[0]  = CH_BSLASH;
            content[1]  = accum_next[7:0];
            content_cnt = 3'd2;
          end else begin
            content[0]  = accum_next[7:0];
            content_cnt = 3'd1;
          end
        end else if (accum_next == 21'h09) begin
          content[0]  = CH_BSLASH;
          content[1]  = CH_LOW_T;
          content_cnt = 3'd2;
        end else if (accum_next == 21'h0A) begin
          content[0]  = CH_BSLASH;
          content[1]  = CH_LOW_N;
          content_cnt = 3'd2;
        end else if (accum_next == 21'h0D) begin
          content[0]  = CH_BSLASH;
          content[1]  = CH_LOW_R;
          content_cnt = 3'd2;
        end else begin
          content[0]  = CH_BSLASH;
          content[1]  = CH_LOW_X;
          content[2]  = hex_char(accum_next[7:4]);
          content[3]  = hex_char(accum_next[3:0]);
          content_cnt = 3'd4;
        end
      end else if (accum_next == 21'hA0) begin
        content[0]  = CH_BSLASH;
        content[1]  = CH_USCORE;
        content_cnt = 3'd2;
      end else if (accum_next == 21'h85) begin
        content[0]  = CH_BSLASH;
        content[1]  = CH_UP_N;
        content_cnt = 3'd2;
      end else if (accum_next == 21'h2028) begin
        content[0]  = CH_BSLASH;
        content[1]  = CH_UP_L;
        content_cnt = 3'd2;
      end else if (accum_next == 21'h2029) begin
        content[0]  = CH_BSLASH;
        content[1]  = CH_UP_P;
        content_cnt = 3'd2;
      end else if (accum_next >= 21'h10000 ||
                   (accum_next >= 21'hA0 && accum_next <= 21'hD7FF) ||
                   (accum_next >= 21'hE000 && accum_next <= 21'hFFFD)) begin
        // Printable multi-byte character: replay the raw bytes.
        for (int k = 0; k < 4; k++) begin
          if (k < 3 && 2'(k) < held_count) begin
            content[k] = held_bytes[k];
          end else if (3'(k) == {1'b0, held_count}) begin
            content[k] = data_byte;
          end
        end
        content_cnt = {1'b0, held_count} + 3'd1;
      end else begin
        content[0]  = CH_BSLASH;
        content[1]  = CH_LOW_U;
        content[2]  = hex_char(accum_next[15:12]);
        content[3]  = hex_char(accum_next[11:8]);
        content[4]  = hex_char(accum_next[7:4]);
        content[5]  = hex_char(accum_next[3:0]);
        content_cnt = 3'd6;
      end
    end
  end

  // Assemble the command: optional opening quote, content, optional closing quote.
  always_comb begin
    logic       open_q;
    logic [3:0] pos;
    open_q = !string_open;
    for (int k = 0; k < NCHAR; k++) begin
      pos = 4'(k) - {3'b000, open_q};
      if (open_q && k == 0) begin
        cmd.chars[k] = CH_QUOTE;
      end else if (pos < {1'b0, content_cnt}) begin
        cmd.chars[k] = content[pos[2:0]];
      end else if (pos == {1'b0, content_cnt} && end_of_string) begin
        cmd.chars[k] = CH_QUOTE;
      end else begin
        cmd.chars[k] = 8'h00;
      end
    end
    cmd.count = {3'b000, open_q} + {1'b0, content_cnt} + {3'b000, end_of_string};
    cmd.close = end_of_string;
    cmd.bad   = end_of_string && (error_next || state_after != ST_ACCEPT);
    push      = accept && cmd.count != 4'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decoder_state <= ST_ACCEPT;
      code_accum    <= 21'd0;
      held_count    <= 2'd0;
      string_open   <= 1'b0;
      error_seen    <= 1'b0;
    end else if (accept) begin
      if (end_of_string) begin
        decoder_state <= ST_ACCEPT;
        code_accum    <= 21'd0;
        held_count    <= 2'd0;
        string_open   <= 1'b0;
        error_seen    <= 1'b0;
      end else begin
        decoder_state <= state_after;
        string_open   <= 1'b1;
        error_seen    <= error_next;
        if (active) begin
          code_accum <= accum_next;
          if (ns == ST_ACCEPT || ns == ST_REJECT) begin
            held_count <= 2'd0;
          end else if (hold_byte) begin
            held_count <= held_count + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_byte) begin
      held_bytes[held_count] <= data_byte;
    end
  end

endmodule

`default_nettype wire

// ===== sv/yqse_queue.sv =====
// ----------------------------------------------------------------------------
// yqse_queue
// Short command queue that decouples the front end from the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module yqse_queue
  import yqse_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire cmd_t              push_cmd,
  input  wire logic              pop,
  output cmd_t                   head,
  output logic                   head_valid,
  output logic [QLVL_W-1:0]      level
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign head       = entries[rd_ptr];
  assign head_valid = (level != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== sv/yqse_back.sv =====
// ----------------------------------------------------------------------------
// yqse_back
// Output sequencer: walks the bytes of the command at the queue head, one
// output byte per cycle unless stalled, and retires it after its last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module yqse_back
  import yqse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       head,
  input  wire logic       head_valid,
  input  wire logic       char_stall,
  output logic            char_valid,
  output logic [7:0]      out_char,
  output logic            out_last,
  output logic            bad_utf8,
  output logic            pop
);

  logic [IDX_W-1:0] idx;
  logic             at_end;
  logic             take;

  assign char_valid = head_valid;
  assign at_end     = ({1'b0, idx} == head.count - 4'd1);
  assign out_char   = head.chars[idx];
  assign out_last   = head.close && at_end;
  assign bad_utf8   = head.bad && out_last;
  assign take       = head_valid && !char_stall;
  assign pop        = take && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      if (at_end) begin
        idx <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/yaml_quoted_string_escaper_unit.sv =====
// ----------------------------------------------------------------------------
// yaml_quoted_string_escaper_unit
// Converts a UTF-8 byte stream into YAML double-quoted text with escapes.
// ----------------------------------------------------------------------------
// Input channel: one source byte per request (data_byte, end_of_string),
// taken when data_valid is high and data_stall is low. end_of_string marks
// the last byte of a string; the next byte starts a new string.
// Output channel: one text byte per request (out_char), taken when
// char_valid is high and char_stall is low. out_last flags the closing quote
// and bad_utf8 on that byte reports malformed or truncated input.
// Each input byte yields zero to eight output bytes. The front end decodes a
// byte in the cycle it is taken and queues its output bytes as one command,
// sent once it reaches the queue head. Input runs at one byte per cycle
// while the four-entry command queue has room; the output sequencer sends
// one byte per cycle while char_stall is low, so escapes of up to eight
// bytes slow the input only once the queue fills. When the receiver stalls,
// the current output byte holds and data_stall rises once the queue is full.
// Reset clears the decoder, the open-string state and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module yaml_quoted_string_escaper_unit
  import yqse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       data_valid,
  output logic            data_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_string,
  output logic            char_valid,
  input  wire logic       char_stall,
  output logic [7:0]      out_char,
  output logic            out_last,
  output logic            bad_utf8
);

  cmd_t              front_cmd;
  logic              push;
  cmd_t              head;
  logic              head_valid;
  logic              pop;
  logic [QLVL_W-1:0] q_level;
  logic              q_full;

  assign q_full = (q_level == LVL_FULL);

  yqse_front u_front (
    .clk           (clk),
    .rst           (rst),
    .data_valid    (data_valid),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .q_full        (q_full),
    .data_stall    (data_stall),
    .push          (push),
    .cmd           (front_cmd)
  );

  yqse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (front_cmd),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .level      (q_level)
  );

  yqse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .char_stall (char_stall),
    .char_valid (char_valid),
    .out_char   (out_char),
    .out_last   (out_last),
    .bad_utf8   (bad_utf8),
    .pop        (pop)
  );

  // The error flag may only ride on the closing quote.
  a_bad_on_last: assert property (@(posedge clk) disable iff (rst)
    char_valid && bad_utf8 |-> out_last)
    else $error("bad_utf8 set on a byte other than the closing quote");

  // A command is never written into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("command pushed into a full queue");

  // Queue occupancy stays within its depth.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= LVL_FULL)
    else $error("command queue level out of range");

  // The sequencer never retires a command the queue does not hold.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid && q_level != '0)
    else $error("command popped from an empty queue");

endmodule

`default_nettype wire

// ===== verif/yaml_quoted_string_escaper_unit_test.sv =====
// ----------------------------------------------------------------------------
// yaml_quoted_string_escaper_unit_test
// Self-checking bench for the YAML double-quoted string escaper. A directed
// table opens the run. It covers the ASCII escapes, the named escapes \_,
// \N and \P, the \u cases, a four-byte pass-through, a malformed byte and a
// truncated tail. Random strings of UTF-8 follow, most of them well formed.
// Each output char is checked against the table text or, for the other
// bytes, an in-bench escaper model. Both ports idle at random; the output is
// held off for long stretches so the command queue fills and input stalls.
// ----------------------------------------------------------------------------
module yaml_quoted_string_escaper_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] DS_ACCEPT = 4'd0;
  localparam logic [3:0] DS_REJECT = 4'd1;
  localparam logic [3:0] DS_LAST   = 4'd8;

  localparam logic [7:0] CH_QT = 8'h22;
  localparam logic [7:0] CH_BS = 8'h5C;

  localparam int RUN_LIMIT    = 400000;
  localparam int RANDOM_ITEMS = 400;
  localparam int MAX_WAIT     = 18;
  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_CHARS    = 8;

  // UTF-8 validation automaton: 9 states by 12 byte classes.
  localparam logic [3:0] UTF8_NEXT [108] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1,
    4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1,
    4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1,
    4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
  };

  localparam logic [7:0] ESC_ASCII [5] = '{8'h22, 8'h5C, 8'h09, 8'h0A, 8'h0D};
  localparam int unsigned SPECIAL_CP [16] = '{
    'hA0, 'h85, 'h80, 'h9F, 'h2028, 'h2029, 'hFFFE, 'hFFFF,
    'hD7FF, 'hE000, 'hFFFD, 'h10000, 'h10FFFF, 'h7FF, 'h800, 'hA1
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       bad;
  } txt_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
  } src_t;

  // Directed row: when typed is set, the first n chars of txt are the
  // expected output, left to right; bad applies to the closing quote.
  typedef struct packed {
    logic [7:0]  b;
    logic        eos;
    logic        typed;
    logic [3:0]  n;
    logic [63:0] txt;
    logic        bad;
  } drow_t;

  localparam int NDIRECTED = 27;
  localparam drow_t DIRECTED [NDIRECTED] = '{
    '{8'h41, 1'b0, 1'b1, 4'd2, "\"A",   1'b0},
    '{8'h00, 1'b0, 1'b1, 4'd4, "\\x00", 1'b0},
    '{8'h7F, 1'b0, 1'b1, 4'd4, "\\x7F", 1'b0},
    '{8'h22, 1'b0, 1'b1, 4'd2, "\\\"",  1'b0},
    '{8'h5C, 1'b0, 1'b1, 4'd2, "\\\\",  1'b0},
    '{8'h09, 1'b0, 1'b1, 4'd2, "\\t",   1'b0},
    '{8'h0A, 1'b0, 1'b1, 4'd2, "\\n",   1'b0},
    '{8'h0D, 1'b0, 1'b1, 4'd2, "\\r",   1'b0},
    '{8'hC2, 1'b0, 1'b0, 4'd0, 64'd0,   1'b0},
    '{8'hA0, 1'b0, 1'b0, 4'd0, 64'd0,   1'b0},
    '{8'hC2, 1'b0, 1'b0, 4'd0, 64'd0,   1'b0},
    '{8'h85, 1'b0, 1'b0, 4'd0, 64'd0,   1'b0},
    '{8'hC2, 1'b0, 1'b0, 4'd0, 64'd0,   1'b0},
    '{8'h9F, 1'b0, 1'b0, 4'd0, 64'd0,   1'b0},
    '{8'hE2, 1'b0, 1'b0, 4'd0, 64'd0,   1'b0},
    '{8'h80, 1'b0, 1'b0, 4'd0, 64'd0,   1'b0},
    '{8'hA9, 1'b0, 1'b0, 4'd0, 64'd0,   1'b0},
    '{8'hEF, 1'b0, 1'b0, 4'd0, 64'd0,   1'b0},
    '{8'hBF, 1'b0, 1'b0, 4'd0, 64'd0,   1'b0},
    '{8'hBF, 1'b0, 1'b0, 4'd0, 64'd0,   1'b0},
    '{8'hF4, 1'b0, 1'b0, 4'd0, 64'd0,   1'b0},
    '{8'h8F, 1'b0, 1'b0, 4'd0, 64'd0,   1'b0},
    '{8'hBF, 1'b0, 1'b0, 4'd0, 64'd0,   1'b0},
    '{8'hBF, 1'b1, 1'b0, 4'd0, 64'd0,   1'b0},
    '{8'hFF, 1'b0, 1'b0, 4'd0, 64'd0,   1'b0},
    '{8'h42, 1'b1, 1'b1, 4'd1, "\"",    1'b1},
    '{8'hE0, 1'b1, 1'b1, 4'd2, "\"\"",  1'b1}
  };

  logic       clk;
  logic       rst;
  logic       data_valid;
  logic       data_stall;
  logic [7:0] data_byte;
  logic       end_of_string;
  logic       char_valid;
  logic       char_stall;
  logic [7:0] out_char;
  logic       out_last;
  logic       bad_utf8;

  yaml_quoted_string_escaper_unit dut (
    .clk           (clk),
    .rst           (rst),
    .data_valid    (data_valid),
    .data_stall    (data_stall),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .out_char      (out_char),
    .out_last      (out_last),
    .bad_utf8      (bad_utf8)
  );

  // Escaper model state.
  logic [3:0]  dec_state;
  logic [20:0] partial_cp;
  logic [7:0]  held [3];
  int unsigned held_n;
  logic        str_open;
  logic        err_flag;

  txt_t pending_chars [$];

  int mismatches    = 0;
  int strings_done  = 0;
  int bytes_sent    = 0;
  int chars_checked = 0;
  int flagged_bad   = 0;
  int stall_cycles  = 0;

  int snd_left = 0;
  bit snd_noidle = 1'b0;
  int rcv_left = 0;
  bit rcv_noidle = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [3:0] class_of(input logic [7:0] b);
    if (b < 8'h80) return 4'd0;
    if (b < 8'h90) return 4'd1;
    if (b < 8'hA0) return 4'd9;
    if (b < 8'hC0) return 4'd7;
    if (b < 8'hC2) return 4'd8;
    if (b < 8'hE0) return 4'd2;
    if (b == 8'hE0) return 4'd10;
    if (b == 8'hED) return 4'd4;
    if (b < 8'hF0) return 4'd3;
    if (b == 8'hF0) return 4'd11;
    if (b < 8'hF4) return 4'd6;
    if (b == 8'hF4) return 4'd5;
    return 4'd8;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + v : 8'h37 + v;
  endfunction

  function automatic void clear_decoder();
    dec_state  = DS_ACCEPT;
    partial_cp = '0;
    held       = '{8'h00, 8'h00, 8'h00};
    held_n     = 0;
    str_open   = 1'b0;
    err_flag   = 1'b0;
  endfunction

  function automatic void put_txt(ref txt_t q[$], input logic [7:0] ch,
                                  input logic last, input logic bad);
    if (q.size() < MAX_CHARS) q.push_back('{ch, last, bad});
  endfunction

  function automatic void put_esc(ref txt_t q[$], input logic [7:0] ch);
    put_txt(q, CH_BS, 1'b0, 1'b0);
    put_txt(q, ch, 1'b0, 1'b0);
  endfunction

  function automatic void put_hex(ref txt_t q[$], input logic [7:0] letter,
                                  input logic [15:0] v, input int digits);
    put_esc(q, letter);
    for (int i = digits - 1; i >= 0; i--) put_txt(q, hex_digit(v[4*i +: 4]), 1'b0, 1'b0);
  endfunction

  function automatic void emit_code(ref txt_t q[$], input logic [20:0] cp,
                                    input logic [7:0] b);
    bit pass;
    if (cp <= 21'h7F) begin
      if (cp >= 21'h20 && cp <= 21'h7E) begin
        if (cp == CH_QT || cp == CH_BS) put_esc(q, cp[7:0]);
        else put_txt(q, cp[7:0], 1'b0, 1'b0);
      end else if (cp == 21'h09) put_esc(q, "t");
      else if (cp == 21'h0A) put_esc(q, "n");
      else if (cp == 21'h0D) put_esc(q, "r");
      else put_hex(q, "x", cp[15:0], 2);
      return;
    end
    if (cp == 21'hA0) begin put_esc(q, "_"); return; end
    if (cp == 21'h85) begin put_esc(q, "N"); return; end
    if (cp == 21'h2028) begin put_esc(q, "L"); return; end
    if (cp == 21'h2029) begin put_esc(q, "P"); return; end
    pass = (cp >= 21'h10000) || (cp >= 21'hA0 && cp <= 21'hD7FF) ||
           (cp >= 21'hE000 && cp <= 21'hFFFD);
    if (!pass) begin
      put_hex(q, "u", cp[15:0], 4);
      return;
    end
    // Printable multi-byte character: the raw bytes go out unchanged.
    for (int i = 0; i < held_n && i < 3; i++) put_txt(q, held[i], 1'b0, 1'b0);
    put_txt(q, b, 1'b0, 1'b0);
  endfunction

  // Escaped text caused by one source byte, with the model state advanced.
  function automatic void escape_byte(input logic [7:0] b, input logic eos,
                                      ref txt_t q[$]);
    logic [3:0] cls;
    logic [3:0] nxt;
    if (!str_open) begin
      put_txt(q, CH_QT, 1'b0, 1'b0);
      str_open = 1'b1;
    end
    if (dec_state > DS_LAST) dec_state = DS_REJECT;
    if (dec_state != DS_REJECT) begin
      cls = class_of(b);
      if (dec_state != DS_ACCEPT) partial_cp = {partial_cp[14:0], b[5:0]};
      else partial_cp = 21'((8'hFF >> cls) & b);
      nxt = UTF8_NEXT[dec_state * 12 + cls];
      if (nxt == DS_ACCEPT) begin
        emit_code(q, partial_cp, b);
        held_n = 0;
      end else if (nxt == DS_REJECT) begin
        err_flag = 1'b1;
        held_n = 0;
      end else if (held_n < 3) begin
        held[held_n] = b;
        held_n++;
      end
      dec_state = nxt;
    end
    if (eos) begin
      put_txt(q, CH_QT, 1'b1, err_flag || (dec_state != DS_ACCEPT));
      clear_decoder();
    end
  endfunction

  function automatic void add_cp(ref logic [7:0] s[$], input int unsigned cp);
    if (cp < 'h80) begin
      s.push_back(8'(cp));
    end else if (cp < 'h800) begin
      s.push_back(8'(8'hC0 | (cp >> 6)));
      s.push_back(8'(8'h80 | (cp & 'h3F)));
    end else if (cp < 'h10000) begin
      s.push_back(8'(8'hE0 | (cp >> 12)));
      s.push_back(8'(8'h80 | ((cp >> 6) & 'h3F)));
      s.push_back(8'(8'h80 | (cp & 'h3F)));
    end else begin
      s.push_back(8'(8'hF0 | (cp >> 18)));
      s.push_back(8'(8'h80 | ((cp >> 12) & 'h3F)));
      s.push_back(8'(8'h80 | ((cp >> 6) & 'h3F)));
      s.push_back(8'(8'h80 | (cp & 'h3F)));
    end
  endfunction

  function automatic int unsigned no_surrogate(input int unsigned cp);
    return (cp >= 'hD800 && cp <= 'hDFFF) ? (cp ^ 'h1000) : cp;
  endfunction

  // One random string. Most are well formed; a quarter carry one stray byte
  // or one cut-off sequence at a random unit of the string.
  function automatic void build_string(ref src_t q[$]);
    logic [7:0] s [$];
    logic [7:0] part [$];
    int units;
    int break_at;
    int kind;
    int cut;
    int unsigned cp;
    units = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
    break_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, units - 1) : -1;
    for (int u = 0; u < units; u++) begin
      if (u == break_at) begin
        if ($urandom_range(0, 1) == 0) begin
          s.push_back(8'($urandom_range(0, 255)));
        end else begin
          part.delete();
          add_cp(part, no_surrogate($urandom_range('h80, 'h10FFFF)));
          cut = $urandom_range(1, part.size() - 1);
          for (int k = 0; k < cut; k++) s.push_back(part[k]);
        end
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 30) cp = $urandom_range('h20, 'h7E);
        else if (kind < 40) cp = $urandom_range(0, 'h7F);
        else if (kind < 46) cp = ESC_ASCII[$urandom_range(0, 4)];
        else if (kind < 60) cp = $urandom_range('h80, 'h7FF);
        else if (kind < 72) cp = no_surrogate($urandom_range('h800, 'hFFFF));
        else if (kind < 84) cp = $urandom_range('h10000, 'h10FFFF);
        else cp = SPECIAL_CP[$urandom_range(0, 15)];
        add_cp(s, cp);
      end
    end
    foreach (s[k]) q.push_back('{s[k], k == s.size() - 1});
  endfunction

  // Idle lengths come in runs: some runs never idle, the rest draw 0..18.
  function automatic int draw_wait(ref int left, ref bit noidle);
    if (left == 0) begin
      left = $urandom_range(20, 60);
      noidle = ($urandom_range(0, 2) == 0);
    end
    left--;
    return noidle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatches < 100)
      $display("%0t ns: mismatch on %s: got %02h, expected %02h", $time, field, got, want);
    mismatches++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = draw_wait(snd_left, snd_noidle);
    if (gap > 0) begin
      data_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    data_valid    <= 1'b1;
    data_byte     <= b;
    end_of_string <= eos;
    @(posedge clk);
    while (data_stall) @(posedge clk);
    bytes_sent++;
    if (eos) strings_done++;
  endtask

  // Output checker: samples the pre-edge values at each rising edge.
  always @(posedge clk) begin
    txt_t want;
    if (!rst && data_valid && data_stall) stall_cycles++;
    if (!rst && char_valid && !char_stall) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected out_char", out_char, 8'h00);
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch) report_mismatch("out_char", out_char, want.ch);
        if (out_last !== want.last) report_mismatch("out_last", out_last, want.last);
        if (bad_utf8 !== want.bad) report_mismatch("bad_utf8", bad_utf8, want.bad);
        chars_checked++;
        if (out_last && bad_utf8) flagged_bad++;
      end
    end
  end

  // Output side. Two long hold-offs let the command queue fill so that the
  // input stalls while the sender keeps offering bytes.
  initial begin
    int n;
    int taken;
    taken = 0;
    char_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == 60 || taken == 400) n = HOLD_CYCLES;
      else n = draw_wait(rcv_left, rcv_noidle);
      if (n > 0) begin
        char_stall <= 1'b1;
        repeat (n) @(posedge clk);
        char_stall <= 1'b0;
      end
      @(posedge clk);
      while (!char_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("yaml_quoted_string_escaper_unit_test: FAIL");
    $finish;
  end

  initial begin
    txt_t  got [$];
    src_t  rnd [$];
    drow_t row;
    rst           <= 1'b1;
    data_valid    <= 1'b0;
    data_byte     <= 8'h00;
    end_of_string <= 1'b0;
    clear_decoder();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NDIRECTED; i++) begin
      row = DIRECTED[i];
      send_byte(row.b, row.eos);
      got.delete();
      escape_byte(row.b, row.eos, got);
      if (row.typed) begin
        got.delete();
        for (int k = 0; k < row.n; k++)
          got.push_back('{row.txt[8*(row.n-1-k) +: 8], row.eos && (k == row.n - 1),
                          row.bad && (k == row.n - 1)});
      end
      foreach (got[j]) pending_chars.push_back(got[j]);
    end

    while (rnd.size() < RANDOM_ITEMS) build_string(rnd);
    foreach (rnd[i]) begin
      send_byte(rnd[i].b, rnd[i].eos);
      got.delete();
      escape_byte(rnd[i].b, rnd[i].eos, got);
      foreach (got[j]) pending_chars.push_back(got[j]);
    end
    data_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Escaped %0d strings from %0d source bytes; %0d output chars checked.",
             strings_done, bytes_sent, chars_checked);
    $display("%0d strings closed with bad_utf8; input stalled by a full queue %0d cycles.",
             flagged_bad, stall_cycles);
    if (mismatches == 0) begin
      $display("yaml_quoted_string_escaper_unit_test: PASS");
    end else begin
      $display("yaml_quoted_string_escaper_unit_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== yaml_quoted_string_escaper_unit.f =====
sv/yqse_pkg.sv
sv/yqse_front.sv
sv/yqse_queue.sv
sv/yqse_back.sv
sv/yaml_quoted_string_escaper_unit.sv
verif/yaml_quoted_string_escaper_unit_test.sv
